/* hw/rtl/bftr_pkg.sv */
// Package for the bitmap font text renderer: sequencer states, item and
// command codes, register indexes, beat layout widths and drawing constants.
// No dependencies.
`timescale 1ns / 1ps

package bftr_pkg;

    // Sequencer states
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FETCH,
        ST_ROW,
        ST_ADVANCE,
        ST_BOX_DARK,
        ST_BOX_INK,
        ST_NEWLINE
    } bftr_state_t;

    // Input item kinds (slave tuser)
    localparam logic [1:0] KIND_FONT_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN_START  = 2'd1;
    localparam logic [1:0] KIND_CHAR       = 2'd2;

    // Draw command kinds (master tuser)
    localparam logic DRAW_ROW  = 1'b0;
    localparam logic DRAW_RECT = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_FONT_LOADED = 2'd0;
    localparam logic [1:0] REG_GLYPH_ROWS  = 2'd1;

    // Beat layout
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 88;
    localparam int FONT_DEPTH = 8192;
    localparam int FONT_AW    = 13;

    // Glyph geometry
    localparam logic [5:0] MAX_GLYPH_ROWS = 6'd32;
    localparam logic [3:0] ROW_PIXELS     = 4'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;

    // Fallback boxes when no font is loaded, cursor advances and line gap
    localparam logic [31:0] BOX_COLOR    = 32'h0020_2020;
    localparam logic [3:0]  BOX_W        = 4'd10;
    localparam logic [4:0]  BOX_H        = 5'd16;
    localparam logic [3:0]  INK_W        = 4'd6;
    localparam logic [4:0]  INK_H        = 5'd10;
    localparam logic [6:0]  INK_DX       = 7'd2;
    localparam logic [6:0]  INK_DY       = 7'd3;
    localparam logic [6:0]  FONT_ADVANCE = 7'd9;
    localparam logic [6:0]  BOX_ADVANCE  = 7'd12;
    localparam logic [6:0]  LINE_GAP     = 7'd2;

endpackage

/* hw/rtl/bitmap_font_text_renderer.sv */
// Bitmap font text renderer top level: sequencer, font memory, shared
// saturating coordinate adder and output register.
// Depends on bftr_pkg.
`timescale 1ns / 1ps

// Each slave beat is one item: a font byte write, the start of a text run
// (position and ink colour) or one character to place at the cursor. Font
// writes and run starts are taken without producing any command. A newline
// moves the cursor down by glyph_rows + 2. With font_loaded set, a character
// (at most 32 glyph rows are used) is accepted, its first glyph byte is
// fetched from the font memory read port, one row command is given per row,
// then the cursor moves right by 9. Without a font, a character gives a dark
// 10x16 box then a 6x10 ink box. The pace is set by the one font memory read
// port, which delivers one glyph row a cycle while the output is not stalled,
// and by the single saturating 16-bit adder shared by all coordinate sums.
// The block takes no new item while a character is in progress; stalls on
// the master side simply hold the sequencer. All coordinates saturate to the
// signed 16-bit range. The font memory is not cleared: glyph bytes must be
// written before a character uses them. Configuration may be written only
// while the block is idle; writes to an unknown index are dropped.
module bitmap_font_text_renderer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [5:0]                        cfg_data,
    // Item stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x_coord[15:0], y_coord[31:16], text_color_in[63:32], char_code[71:64],
    // font_address[84:72], font_byte[92:85], zero[95:93]
    input  logic [bftr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                        s_axis_tuser,
    // Draw command stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // draw_x[15:0], draw_y[31:16], draw_width[35:32], draw_height[40:36],
    // row_mask[48:41], draw_color[80:49], zero[87:81]
    output logic [bftr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // draw_kind[0]
    output logic                              m_axis_tuser,
    // last_of_run
    output logic                              m_axis_tlast
);

    // ------------------------------------------------------------------
    // Unpack the slave beat
    // ------------------------------------------------------------------
    logic signed [15:0]            in_x;
    logic signed [15:0]            in_y;
    logic [31:0]                   in_color;
    logic [7:0]                    in_char;
    logic [bftr_pkg::FONT_AW-1:0]  in_addr;
    logic [7:0]                    in_byte;

    assign in_x     = s_axis_tdata[15:0];
    assign in_y     = s_axis_tdata[31:16];
    assign in_color = s_axis_tdata[63:32];
    assign in_char  = s_axis_tdata[71:64];
    assign in_addr  = s_axis_tdata[84:72];
    assign in_byte  = s_axis_tdata[92:85];

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    bftr_pkg::bftr_state_t state_reg, state_next;

    logic                          font_loaded_reg;
    logic [5:0]                    glyph_rows_reg;
    logic signed [15:0]            cursor_x_reg, cursor_x_next;
    logic signed [15:0]            line_start_x_reg, line_start_x_next;
    logic signed [15:0]            cursor_y_reg, cursor_y_next;
    logic [31:0]                   ink_color_reg, ink_color_next;
    logic [5:0]                    row_reg, row_next;
    logic [bftr_pkg::FONT_AW-1:0]  base_addr_reg, base_addr_next;
    logic signed [15:0]            ink_x_reg, ink_x_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_kind_reg, out_kind_next;
    logic signed [15:0]            out_x_reg, out_x_next;
    logic signed [15:0]            out_y_reg, out_y_next;
    logic [3:0]                    out_w_reg, out_w_next;
    logic [4:0]                    out_h_reg, out_h_next;
    logic [7:0]                    out_mask_reg, out_mask_next;
    logic [31:0]                   out_color_reg, out_color_next;
    logic                          out_last_reg, out_last_next;

    // Font memory and its registered read port
    logic [7:0]                    font_mem [bftr_pkg::FONT_DEPTH];
    logic [7:0]                    rd_data_reg;
    logic                          rd_en;
    logic [bftr_pkg::FONT_AW-1:0]  rd_addr;
    logic                          wr_en;

    // Handshake helpers
    logic                          in_fire;
    logic                          out_free;
    logic                          out_load;
    logic [5:0]                    rows_used;
    logic                          last_row;
    logic [13:0]                   glyph_base;

    assign s_axis_tready = (state_reg == bftr_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // Clamp the glyph height to what the font memory layout allows
    assign rows_used  = (glyph_rows_reg > bftr_pkg::MAX_GLYPH_ROWS)
                      ? bftr_pkg::MAX_GLYPH_ROWS : glyph_rows_reg;
    assign last_row   = (row_reg + 6'd1) == rows_used;
    assign glyph_base = {6'd0, in_char} * {8'd0, rows_used};

    // ------------------------------------------------------------------
    // Shared saturating adder: a signed coordinate plus a small offset.
    // The offset is never negative, so only the upper bound can be crossed.
    // ------------------------------------------------------------------
    logic signed [15:0]  add_a;
    logic [6:0]          add_b;
    logic signed [16:0]  add_sum;
    logic signed [15:0]  add_sat;

    assign add_sum = {add_a[15], add_a} + {10'd0, add_b};
    assign add_sat = (add_sum[16:15] == 2'b01) ? 16'sh7FFF : add_sum[15:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bftr_pkg::ST_IDLE:
            begin
                if (in_fire && s_axis_tuser == bftr_pkg::KIND_CHAR)
                begin
                    if (in_char == bftr_pkg::CODE_NEWLINE)
                        state_next = bftr_pkg::ST_NEWLINE;
                    else if (!font_loaded_reg)
                        state_next = bftr_pkg::ST_BOX_DARK;
                    else if (rows_used == 6'd0)
                        state_next = bftr_pkg::ST_ADVANCE;
                    else
                        state_next = bftr_pkg::ST_FETCH;
                end
            end
            bftr_pkg::ST_FETCH:
                state_next = bftr_pkg::ST_ROW;
            bftr_pkg::ST_ROW:
            begin
                if (out_free && last_row)
                    state_next = bftr_pkg::ST_ADVANCE;
            end
            bftr_pkg::ST_BOX_DARK:
            begin
                if (out_free)
                    state_next = bftr_pkg::ST_BOX_INK;
            end
            bftr_pkg::ST_BOX_INK:
            begin
                if (out_free)
                    state_next = bftr_pkg::ST_ADVANCE;
            end
            bftr_pkg::ST_ADVANCE:
                state_next = bftr_pkg::ST_IDLE;
            bftr_pkg::ST_NEWLINE:
                state_next = bftr_pkg::ST_IDLE;
            default:
                state_next = bftr_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control and command formation
    // ------------------------------------------------------------------
    always_comb
    begin
        cursor_x_next     = cursor_x_reg;
        line_start_x_next = line_start_x_reg;
        cursor_y_next     = cursor_y_reg;
        ink_color_next    = ink_color_reg;
        row_next          = row_reg;
        base_addr_next    = base_addr_reg;
        ink_x_next        = ink_x_reg;

        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_w_next     = out_w_reg;
        out_h_next     = out_h_reg;
        out_mask_next  = out_mask_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        add_a   = cursor_y_reg;
        add_b   = 7'd0;
        rd_en   = 1'b0;
        rd_addr = base_addr_reg;
        wr_en   = 1'b0;

        case (state_reg)
            bftr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_axis_tuser)
                        bftr_pkg::KIND_FONT_WRITE:
                            wr_en = 1'b1;
                        bftr_pkg::KIND_RUN_START:
                        begin
                            cursor_x_next     = in_x;
                            line_start_x_next = in_x;
                            cursor_y_next     = in_y;
                            ink_color_next    = in_color;
                        end
                        bftr_pkg::KIND_CHAR:
                        begin
                            // Latch the glyph's first byte address
                            base_addr_next = glyph_base[bftr_pkg::FONT_AW-1:0];
                            row_next       = 6'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bftr_pkg::ST_FETCH:
            begin
                rd_en   = 1'b1;
                rd_addr = base_addr_reg;
            end
            bftr_pkg::ST_ROW:
            begin
                add_a = cursor_y_reg;
                add_b = {1'b0, row_reg};
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = bftr_pkg::DRAW_ROW;
                    out_x_next     = cursor_x_reg;
                    out_y_next     = add_sat;
                    out_w_next     = bftr_pkg::ROW_PIXELS;
                    out_h_next     = 5'd1;
                    out_mask_next  = rd_data_reg;
                    out_color_next = ink_color_reg;
                    out_last_next  = last_row;
                    row_next       = row_reg + 6'd1;
                    // Fetch the next glyph byte while this row leaves
                    if (!last_row)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = base_addr_reg + {7'd0, row_next};
                    end
                end
            end
            bftr_pkg::ST_BOX_DARK:
            begin
                add_a = cursor_x_reg;
                add_b = bftr_pkg::INK_DX;
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = bftr_pkg::DRAW_RECT;
                    out_x_next     = cursor_x_reg;
                    out_y_next     = cursor_y_reg;
                    out_w_next     = bftr_pkg::BOX_W;
                    out_h_next     = bftr_pkg::BOX_H;
                    out_mask_next  = 8'd0;
                    out_color_next = bftr_pkg::BOX_COLOR;
                    out_last_next  = 1'b0;
                    ink_x_next     = add_sat;
                end
            end
            bftr_pkg::ST_BOX_INK:
            begin
                add_a = cursor_y_reg;
                add_b = bftr_pkg::INK_DY;
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = bftr_pkg::DRAW_RECT;
                    out_x_next     = ink_x_reg;
                    out_y_next     = add_sat;
                    out_w_next     = bftr_pkg::INK_W;
                    out_h_next     = bftr_pkg::INK_H;
                    out_mask_next  = 8'd0;
                    out_color_next = ink_color_reg;
                    out_last_next  = 1'b1;
                end
            end
            bftr_pkg::ST_ADVANCE:
            begin
                add_a         = cursor_x_reg;
                add_b         = font_loaded_reg ? bftr_pkg::FONT_ADVANCE
                                                : bftr_pkg::BOX_ADVANCE;
                cursor_x_next = add_sat;
            end
            bftr_pkg::ST_NEWLINE:
            begin
                // Newline uses the programmed row count, not the clamped one
                add_a         = cursor_y_reg;
                add_b         = {1'b0, glyph_rows_reg} + bftr_pkg::LINE_GAP;
                cursor_y_next = add_sat;
                cursor_x_next = line_start_x_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Hold a command until taken; refill in the same cycle it leaves
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bftr_pkg::ST_IDLE;
            font_loaded_reg  <= 1'b0;
            glyph_rows_reg   <= 6'd0;
            cursor_x_reg     <= '0;
            line_start_x_reg <= '0;
            cursor_y_reg     <= '0;
            ink_color_reg    <= '0;
            row_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cursor_x_reg     <= cursor_x_next;
            line_start_x_reg <= line_start_x_next;
            cursor_y_reg     <= cursor_y_next;
            ink_color_reg    <= ink_color_next;
            row_reg          <= row_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bftr_pkg::REG_FONT_LOADED: font_loaded_reg <= cfg_data[0];
                    bftr_pkg::REG_GLYPH_ROWS:  glyph_rows_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        base_addr_reg <= base_addr_next;
        ink_x_reg     <= ink_x_next;
        out_kind_reg  <= out_kind_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_w_reg     <= out_w_next;
        out_h_reg     <= out_h_next;
        out_mask_reg  <= out_mask_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Font memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            font_mem[in_addr] <= in_byte;
        if (rd_en)
            rd_data_reg <= font_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Master beat
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_color_reg, out_mask_reg, out_h_reg, out_w_reg,
                            out_y_reg, out_x_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The row counter stays inside the glyph while rows are emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bftr_pkg::ST_ROW) |-> (row_reg < rows_used))
        else $error("glyph row counter ran past the glyph height");

    // An accepted character, newline included, always moves the sequencer out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser == bftr_pkg::KIND_CHAR) |=>
            (state_reg != bftr_pkg::ST_IDLE))
        else $error("character accepted without starting the sequencer");

    // Masked row commands are always one row of the glyph width
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == bftr_pkg::DRAW_ROW) |->
            (out_w_reg == bftr_pkg::ROW_PIXELS && out_h_reg == 5'd1))
        else $error("masked row command with wrong geometry");

    // Each command finished by the sequencer is loaded only into a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> m_axis_tready)
        else $error("command register overwritten before it was taken");

endmodule

/* bench/tb_bitmap_font_text_renderer.sv */
// Self-checking bench for the bitmap font text renderer: drives item and
// configuration beats, predicts every draw command and checks each result beat.
// Depends on bftr_pkg and bitmap_font_text_renderer.
`timescale 1ns / 1ps

module tb_bitmap_font_text_renderer;

    import bftr_pkg::*;

    // Item kind that the block must drop without a trace
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Register indexes with nothing behind them
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam int LONG_HOLD   = 300;     // receiver hold-off, in cycles
    localparam int IDLE_CYCLES = 50;      // quiet time before a register write
    localparam int TAIL_CYCLES = 60;      // watch for stray beats at the end
    localparam int RUN_LIMIT   = 4000000; // ns

    // One draw command, one field per output field
    typedef struct packed
    {
        logic        draw_kind;
        logic [15:0] draw_x;
        logic [15:0] draw_y;
        logic [3:0]  draw_width;
        logic [4:0]  draw_height;
        logic [7:0]  row_mask;
        logic [31:0] draw_color;
        logic        last_of_run;
    } draw_cmd_t;

    // Predicts the draw commands of each accepted item and checks result beats
    // against them in order.
    class draw_scoreboard;
        bit          font_on;
        logic [5:0]  rows_cfg;
        logic [15:0] pen_x;
        logic [15:0] run_left_x;
        logic [15:0] pen_y;
        logic [31:0] ink;
        logic [7:0]  glyph_mem [0:FONT_DEPTH-1];
        draw_cmd_t   pending_cmds [$];
        int          errors;

        function new();
            font_on    = 1'b0;
            rows_cfg   = '0;
            pen_x      = '0;
            run_left_x = '0;
            pen_y      = '0;
            ink        = '0;
            errors     = 0;
        endfunction

        // Signed 16-bit sum, clamped to the representable range
        function logic [15:0] clamp_add(logic [15:0] base, int delta);
            int sum;
            sum = int'($signed(base)) + delta;
            if (sum > 32767)
                sum = 32767;
            else if (sum < -32768)
                sum = -32768;
            return 16'(sum);
        endfunction

        function void write_register(logic [1:0] index, logic [5:0] value);
            case (index)
                REG_FONT_LOADED: font_on  = value[0];
                REG_GLYPH_ROWS:  rows_cfg = value;
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] kind, logic [IN_DATA_W-1:0] data);
            logic [7:0] code;
            draw_cmd_t  cmd;
            int         rows;
            int         addr;
            code = data[71:64];
            case (kind)
                KIND_FONT_WRITE:
                    glyph_mem[data[84:72]] = data[92:85];
                KIND_RUN_START:
                begin
                    pen_x      = data[15:0];
                    run_left_x = data[15:0];
                    pen_y      = data[31:16];
                    ink        = data[63:32];
                end
                KIND_CHAR:
                begin
                    if (code == CODE_NEWLINE)
                    begin
                        pen_y = clamp_add(pen_y, int'(rows_cfg) + int'(LINE_GAP));
                        pen_x = run_left_x;
                    end
                    else if (font_on)
                    begin
                        rows = (rows_cfg > MAX_GLYPH_ROWS) ? int'(MAX_GLYPH_ROWS)
                                                           : int'(rows_cfg);
                        for (int r = 0; r < rows; r++)
                        begin
                            addr = (int'(code) * rows + r) % FONT_DEPTH;
                            cmd.draw_kind   = DRAW_ROW;
                            cmd.draw_x      = pen_x;
                            cmd.draw_y      = clamp_add(pen_y, r);
                            cmd.draw_width  = ROW_PIXELS;
                            cmd.draw_height = 5'd1;
                            cmd.row_mask    = glyph_mem[addr];
                            cmd.draw_color  = ink;
                            cmd.last_of_run = (r == rows - 1);
                            pending_cmds.push_back(cmd);
                        end
                        pen_x = clamp_add(pen_x, int'(FONT_ADVANCE));
                    end
                    else
                    begin
                        // dark backing box, then the ink box inset within it
                        cmd.draw_kind   = DRAW_RECT;
                        cmd.draw_x      = pen_x;
                        cmd.draw_y      = pen_y;
                        cmd.draw_width  = BOX_W;
                        cmd.draw_height = BOX_H;
                        cmd.row_mask    = '0;
                        cmd.draw_color  = BOX_COLOR;
                        cmd.last_of_run = 1'b0;
                        pending_cmds.push_back(cmd);
                        cmd.draw_x      = clamp_add(pen_x, int'(INK_DX));
                        cmd.draw_y      = clamp_add(pen_y, int'(INK_DY));
                        cmd.draw_width  = INK_W;
                        cmd.draw_height = INK_H;
                        cmd.draw_color  = ink;
                        cmd.last_of_run = 1'b1;
                        pending_cmds.push_back(cmd);
                        pen_x = clamp_add(pen_x, int'(BOX_ADVANCE));
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, name, want, got);
            end
        endfunction

        function void check_command(draw_cmd_t got);
            draw_cmd_t want;
            if (pending_cmds.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected draw beat, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_cmds.pop_front();
            compare_field("draw_kind",   32'(want.draw_kind),   32'(got.draw_kind));
            compare_field("draw_x",      32'(want.draw_x),      32'(got.draw_x));
            compare_field("draw_y",      32'(want.draw_y),      32'(got.draw_y));
            compare_field("draw_width",  32'(want.draw_width),  32'(got.draw_width));
            compare_field("draw_height", 32'(want.draw_height), 32'(got.draw_height));
            compare_field("row_mask",    32'(want.row_mask),    32'(got.row_mask));
            compare_field("draw_color",  want.draw_color,       got.draw_color);
            compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [5:0]            cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    draw_scoreboard sb;
    draw_cmd_t      seen_cmd;

    // Stimulus-side view of the block: which font bytes hold data, and the
    // configuration in force, so that no glyph ever reads an unwritten byte.
    bit         font_written [0:FONT_DEPTH-1];
    bit         gen_font;
    logic [5:0] gen_rows;

    // Pacing controls shared by the two sides
    bit send_burst;
    bit recv_burst;
    bit hold_req;

    bitmap_font_text_renderer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a beat
    initial
    begin
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Observe every handshake at the rising edge. Check results before noting
    // a new item: nothing accepted on this edge can have produced a beat yet.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_cmd.draw_kind   = m_axis_tuser;
                seen_cmd.draw_x      = m_axis_tdata[15:0];
                seen_cmd.draw_y      = m_axis_tdata[31:16];
                seen_cmd.draw_width  = m_axis_tdata[35:32];
                seen_cmd.draw_height = m_axis_tdata[40:36];
                seen_cmd.row_mask    = m_axis_tdata[48:41];
                seen_cmd.draw_color  = m_axis_tdata[80:49];
                seen_cmd.last_of_run = m_axis_tlast;
                sb.check_command(seen_cmd);
            end
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tuser, s_axis_tdata);
        end
    end

    // Result sink: draw a stall before each beat, or take a long hold-off
    // when asked, so that the block backs up into its input.
    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = recv_burst ? 0 : $urandom_range(0, 8);
            if (hold_req)
            begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [15:0] x, logic [15:0] y,
                                                        logic [31:0] color, logic [7:0] code,
                                                        logic [12:0] addr,
                                                        logic [7:0] fbyte);
        return {3'b000, fbyte, addr, code, color, y, x};
    endfunction

    // Offer one item beat. Enter and leave at a falling edge with tvalid
    // still high, so a back-to-back beat never toggles it within one step.
    task automatic send_item(input logic [1:0] kind, input logic [IN_DATA_W-1:0] data);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Fields a kind does not use are always filled with noise
    task automatic font_write(input logic [12:0] addr, input logic [7:0] fbyte);
        font_written[addr] = 1'b1;
        send_item(KIND_FONT_WRITE, pack_item(16'($urandom), 16'($urandom), $urandom,
                                             8'($urandom), addr, fbyte));
    endtask

    task automatic run_start(input logic [15:0] x, input logic [15:0] y,
                             input logic [31:0] color);
        send_item(KIND_RUN_START, pack_item(x, y, color, 8'($urandom),
                                            13'($urandom), 8'($urandom)));
    endtask

    task automatic place_char(input logic [7:0] code);
        send_item(KIND_CHAR, pack_item(16'($urandom), 16'($urandom), $urandom, code,
                                       13'($urandom), 8'($urandom)));
    endtask

    task automatic send_noise();
        send_item(KIND_UNUSED, pack_item(16'($urandom), 16'($urandom), $urandom,
                                         8'($urandom), 13'($urandom), 8'($urandom)));
    endtask

    // Fill in any glyph byte the character is about to read but that holds
    // no data yet
    task automatic prepare_glyph(input logic [7:0] code);
        int rows;
        int addr;
        if (gen_font && code != CODE_NEWLINE)
        begin
            rows = (gen_rows > MAX_GLYPH_ROWS) ? int'(MAX_GLYPH_ROWS) : int'(gen_rows);
            for (int r = 0; r < rows; r++)
            begin
                addr = (int'(code) * rows + r) % FONT_DEPTH;
                if (!font_written[addr])
                    font_write(13'(addr), 8'($urandom));
            end
        end
    endtask

    task automatic place_glyph(input logic [7:0] code);
        prepare_glyph(code);
        place_char(code);
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Drop tvalid and hold the sender until every command has come out
    task automatic pause_for_results();
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        @(negedge clk);
    endtask

    // Bring the block to rest before touching its registers; items that give
    // no command may still be in progress when the last beat has left.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_beat(input logic [1:0] index, input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Write both registers, then poke a spare index that must be ignored
    task automatic configure(input bit font, input logic [5:0] rows);
        gen_font = font;
        gen_rows = rows;
        cfg_beat(REG_FONT_LOADED, {5'($urandom), font});
        cfg_beat(REG_GLYPH_ROWS, rows);
        cfg_beat($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 6'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0]  code_pool [0:3];
        logic [7:0]  code;
        logic [5:0]  rows;
        logic [15:0] x;
        logic [15:0] y;
        bit          font;
        int          pick;

        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;
        hold_req      = 1'b0;
        gen_font      = 1'b0;
        gen_rows      = '0;
        foreach (font_written[a])
            font_written[a] = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Box mode: a character before any run uses the reset cursor and ink,
        // then push the cursor against the top of the range on both axes.
        configure(1'b0, 6'd16);
        place_char(8'd65);
        run_start(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        place_char(8'd0);
        place_char(8'd255);
        place_char(CODE_NEWLINE);
        send_noise();
        run_start(16'h8000, 16'h8000, 32'h0000_0000);
        place_char(CODE_NEWLINE);
        place_char(8'd66);
        settle();

        // Font mode with tiny glyphs: a blank row still gives a command, and
        // the x advance clips at the right edge.
        configure(1'b1, 6'd2);
        font_write(13'h1FFF, 8'hFF);
        font_write(13'h0000, 8'h00);
        run_start(16'd32760, 16'd100, 32'h00A5_5A0F);
        place_glyph(8'd0);
        place_glyph(8'd255);
        place_char(CODE_NEWLINE);
        settle();

        // Zero glyph rows: no commands but the cursor still moves
        configure(1'b1, 6'd0);
        place_char(8'd65);
        place_char(CODE_NEWLINE);
        settle();

        // Oversized glyph count clips to the maximum; the last glyph of the
        // set reaches the top font address.
        configure(1'b1, 6'd63);
        run_start(16'd100, 16'd32760, 32'h1234_5678);
        place_glyph(8'd255);
        place_char(CODE_NEWLINE);
        settle();

        // Random phases: fresh settings each time, mostly characters from a
        // small pool so glyph data gets reused, mixed with runs, newlines,
        // stray font writes, ignored kinds and pauses.
        for (int p = 0; p < 8; p++)
        begin
            font = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       rows = 6'd0;
                1:       rows = 6'd32;
                2:       rows = 6'd63;
                3:       rows = 6'd1;
                default: rows = 6'($urandom_range(1, 16));
            endcase
            if (p == 1)
            begin
                font = 1'b1;
                rows = 6'd8;
            end
            configure(font, rows);
            send_burst = ($urandom_range(0, 2) == 0);
            recv_burst = ($urandom_range(0, 2) == 0);
            foreach (code_pool[k])
            begin
                code_pool[k] = 8'($urandom);
                if (code_pool[k] == CODE_NEWLINE)
                    code_pool[k] = code_pool[k] + 8'd1;
            end

            // Back the block up: hold the sink off while characters keep
            // being offered back to back.
            if (p == 1)
            begin
                foreach (code_pool[k])
                    prepare_glyph(code_pool[k]);
                hold_req   = 1'b1;
                send_burst = 1'b1;
            end

            for (int i = 0; i < 16; i++)
            begin
                pick = $urandom_range(0, 99);
                if (p == 1)
                    place_char(code_pool[i % 4]);
                else if (pick < 10)
                begin
                    x = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(32700, 32767))
                                                    : 16'($urandom);
                    y = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(32700, 32767))
                                                    : 16'($urandom);
                    run_start(x, y, $urandom);
                end
                else if (pick < 20)
                    place_char(CODE_NEWLINE);
                else if (pick < 28)
                    font_write(13'($urandom), 8'($urandom));
                else if (pick < 32)
                    send_noise();
                else if (pick < 36)
                    pause_for_results();
                else
                begin
                    code = (pick < 90) ? code_pool[$urandom_range(0, 3)] : 8'($urandom);
                    place_glyph(code);
                end
            end
            send_burst = 1'b0;
            recv_burst = 1'b0;
            settle();
        end

        // Everything sent: let the last commands out and watch for strays
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
